// ===== rtl/core/indexed_min_heap_decrease_key_assert.svh =====
// Assertion macros used by the heap sequencer.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_ASSERT_SVH

// Implication whose consequent is checked in the cycle after the antecedent, disabled while in reset.
`define IHDK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Property that holds on every clock edge outside reset.
`define IHDK_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== rtl/core/ihdk_pkg.sv =====
// Package with shared types, codes and compare function for the heap.
`timescale 1ns / 1ps
package ihdk_pkg;

  localparam int MAX_VERTICES_DEF = 1024;

  localparam logic [1:0] REQ_INSERT   = 2'd0;
  localparam logic [1:0] REQ_DECREASE = 2'd1;
  localparam logic [1:0] REQ_EXTRACT  = 2'd2;
  localparam logic [1:0] REQ_LOOKUP   = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_SMALLER = 3'd1;
  localparam logic [2:0] ST_PRESENT     = 3'd2;
  localparam logic [2:0] ST_ABSENT      = 3'd3;
  localparam logic [2:0] ST_EMPTY_FULL  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  vertex_id;
    logic [31:0] key_distance;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  out_vertex;
    logic [31:0] out_distance;
    logic        is_present;
    logic [10:0] heap_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [9:0]  vert;
  } entry_t;

  // Strict heap order: smaller distance first, lower vertex id on ties.
  function automatic logic entry_less(entry_t a, entry_t b);
    return (a.key != b.key) ? (a.key < b.key) : (a.vert < b.vert);
  endfunction

endpackage

// ===== rtl/core/ihdk_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ihdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ihdk_ctrl.sv =====
// Request sequencer: position lookup, sift up and sift down over the RAMs.
`timescale 1ns / 1ps
module ihdk_ctrl #(
  parameter int MAX_VERTICES = ihdk_pkg::MAX_VERTICES_DEF,
  parameter int SW  = $clog2(MAX_VERTICES),
  parameter int CW  = $clog2(MAX_VERTICES + 1),
  parameter int PIW = $clog2((MAX_VERTICES < 1024) ? MAX_VERTICES : 1024)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ihdk_pkg::req_t        req,
  output logic                  done,
  output ihdk_pkg::rsp_t        result,
  output logic                  s_we,
  output logic [SW-1:0]         s_waddr,
  output ihdk_pkg::entry_t      s_wdata,
  output logic [SW-1:0]         s_raddr,
  input  ihdk_pkg::entry_t      s_rdata,
  output logic                  p_we,
  output logic [PIW-1:0]        p_waddr,
  output logic [CW-1:0]         p_wdata,
  output logic [PIW-1:0]        p_raddr,
  input  logic [CW-1:0]         p_rdata
);
  import ihdk_pkg::*;

  localparam int PM_DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam int LW = SW + 2;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_POSCHK  = 4'd2;
  localparam logic [3:0] S_SLOTCHK = 4'd3;
  localparam logic [3:0] S_UP      = 4'd4;
  localparam logic [3:0] S_UPCMP   = 4'd5;
  localparam logic [3:0] S_EXROOT  = 4'd6;
  localparam logic [3:0] S_EXLAST  = 4'd7;
  localparam logic [3:0] S_DN      = 4'd8;
  localparam logic [3:0] S_DNL     = 4'd9;
  localparam logic [3:0] S_DNR     = 4'd10;
  localparam logic [3:0] S_DNCMP   = 4'd11;

  logic [3:0]     state, state_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [SW-1:0]  idx, idx_next;
  logic [SW-1:0]  bidx, bidx_next;
  entry_t         cur, cur_next;
  entry_t         best, best_next;
  entry_t         root, root_next;
  req_t           rq, rq_next;
  logic [PIW-1:0] clr, clr_next;
  logic           done_next;
  rsp_t           result_next;

  logic           in_range;
  logic [CW-1:0]  posv;
  logic [SW-1:0]  parent;
  logic [LW-1:0]  lidx;
  logic [LW-1:0]  ridx;

  function automatic rsp_t make_rsp(logic [2:0] st, logic [9:0] ov, logic [31:0] od,
                                    logic pr, logic [10:0] hc);
    rsp_t r;
    r.status       = st;
    r.out_vertex   = ov;
    r.out_distance = od;
    r.is_present   = pr;
    r.heap_count   = hc;
    return r;
  endfunction

  assign busy     = (state != S_IDLE);
  assign in_range = ({22'd0, rq.vertex_id} < 32'(MAX_VERTICES));
  assign posv     = in_range ? p_rdata : '0;
  assign parent   = (idx - SW'(1)) >> 1;
  assign lidx     = {1'b0, idx, 1'b1};
  assign ridx     = lidx + LW'(1);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    idx_next    = idx;
    bidx_next   = bidx;
    cur_next    = cur;
    best_next   = best;
    root_next   = root;
    rq_next     = rq;
    clr_next    = clr;
    done_next   = 1'b0;
    result_next = result;
    s_we        = 1'b0;
    s_waddr     = idx;
    s_wdata     = cur;
    s_raddr     = '0;
    p_we        = 1'b0;
    p_waddr     = cur.vert[PIW-1:0];
    p_wdata     = CW'(idx) + CW'(1);
    p_raddr     = req.vertex_id[PIW-1:0];
    unique case (state)
      S_CLR: begin
        p_we     = 1'b1;
        p_waddr  = clr;
        p_wdata  = '0;
        clr_next = clr + PIW'(1);
        if (clr == PIW'(PM_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          rq_next = req;
          if (req.req_type == REQ_EXTRACT) begin
            if (cnt == '0) begin
              done_next   = 1'b1;
              result_next = make_rsp(ST_EMPTY_FULL, '0, '0, 1'b0, 11'(cnt));
            end else begin
              s_raddr    = '0;
              state_next = S_EXROOT;
            end
          end else begin
            state_next = S_POSCHK;
          end
        end
      end
      S_POSCHK: begin
        if (rq.req_type == REQ_INSERT) begin
          if (!in_range || cnt == CW'(MAX_VERTICES)) begin
            done_next   = 1'b1;
            result_next = make_rsp(ST_EMPTY_FULL, '0, '0, 1'b0, 11'(cnt));
            state_next  = S_IDLE;
          end else if (posv != '0) begin
            done_next   = 1'b1;
            result_next = make_rsp(ST_PRESENT, '0, '0, 1'b0, 11'(cnt));
            state_next  = S_IDLE;
          end else begin
            cur_next   = '{key: rq.key_distance, vert: rq.vertex_id};
            idx_next   = SW'(cnt);
            cnt_next   = cnt + CW'(1);
            state_next = S_UP;
          end
        end else if (posv == '0) begin
          done_next   = 1'b1;
          result_next = make_rsp(ST_ABSENT,
                                 (rq.req_type == REQ_LOOKUP) ? rq.vertex_id : 10'd0,
                                 '0, 1'b0, 11'(cnt));
          state_next  = S_IDLE;
        end else begin
          s_raddr    = SW'(posv - CW'(1));
          idx_next   = SW'(posv - CW'(1));
          state_next = S_SLOTCHK;
        end
      end
      S_SLOTCHK: begin
        if (rq.req_type == REQ_LOOKUP) begin
          done_next   = 1'b1;
          result_next = make_rsp(ST_OK, rq.vertex_id, s_rdata.key, 1'b1, 11'(cnt));
          state_next  = S_IDLE;
        end else if (rq.key_distance >= s_rdata.key) begin
          done_next   = 1'b1;
          result_next = make_rsp(ST_NOT_SMALLER, '0, '0, 1'b0, 11'(cnt));
          state_next  = S_IDLE;
        end else begin
          cur_next   = '{key: rq.key_distance, vert: rq.vertex_id};
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (idx == '0) begin
          s_we        = 1'b1;
          p_we        = 1'b1;
          done_next   = 1'b1;
          result_next = make_rsp(ST_OK, '0, '0, 1'b0, 11'(cnt));
          state_next  = S_IDLE;
        end else begin
          s_raddr    = parent;
          state_next = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (entry_less(cur, s_rdata)) begin
          s_we       = 1'b1;
          s_wdata    = s_rdata;
          p_we       = 1'b1;
          p_waddr    = s_rdata.vert[PIW-1:0];
          idx_next   = parent;
          state_next = S_UP;
        end else begin
          s_we        = 1'b1;
          p_we        = 1'b1;
          done_next   = 1'b1;
          result_next = make_rsp(ST_OK, '0, '0, 1'b0, 11'(cnt));
          state_next  = S_IDLE;
        end
      end
      S_EXROOT: begin
        root_next = s_rdata;
        p_we      = 1'b1;
        p_waddr   = s_rdata.vert[PIW-1:0];
        p_wdata   = '0;
        cnt_next  = cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done_next   = 1'b1;
          result_next = make_rsp(ST_OK, s_rdata.vert, s_rdata.key, 1'b0, 11'(cnt_next));
          state_next  = S_IDLE;
        end else begin
          s_raddr    = SW'(cnt - CW'(1));
          state_next = S_EXLAST;
        end
      end
      S_EXLAST: begin
        cur_next   = s_rdata;
        idx_next   = '0;
        state_next = S_DN;
      end
      S_DN: begin
        if (lidx >= LW'(cnt)) begin
          s_we        = 1'b1;
          p_we        = 1'b1;
          done_next   = 1'b1;
          result_next = make_rsp(ST_OK, root.vert, root.key, 1'b0, 11'(cnt));
          state_next  = S_IDLE;
        end else begin
          s_raddr    = lidx[SW-1:0];
          state_next = S_DNL;
        end
      end
      S_DNL: begin
        best_next = s_rdata;
        bidx_next = lidx[SW-1:0];
        if (ridx < LW'(cnt)) begin
          s_raddr    = ridx[SW-1:0];
          state_next = S_DNR;
        end else begin
          state_next = S_DNCMP;
        end
      end
      S_DNR: begin
        if (entry_less(s_rdata, best)) begin
          best_next = s_rdata;
          bidx_next = ridx[SW-1:0];
        end
        state_next = S_DNCMP;
      end
      S_DNCMP: begin
        if (entry_less(best, cur)) begin
          s_we       = 1'b1;
          s_wdata    = best;
          p_we       = 1'b1;
          p_waddr    = best.vert[PIW-1:0];
          idx_next   = bidx;
          state_next = S_DN;
        end else begin
          s_we        = 1'b1;
          p_we        = 1'b1;
          done_next   = 1'b1;
          result_next = make_rsp(ST_OK, root.vert, root.key, 1'b0, 11'(cnt));
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt   <= '0;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      clr   <= clr_next;
      done  <= done_next;
    end
    idx    <= idx_next;
    bidx   <= bidx_next;
    cur    <= cur_next;
    best   <= best_next;
    root   <= root_next;
    rq     <= rq_next;
    result <= result_next;
  end

`include "indexed_min_heap_decrease_key_assert.svh"
  `IHDK_ASSERT_ALWAYS(a_done_idle, !done || !busy, "result strobe outside the idle state")
  `IHDK_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done, "accepted word was dropped")
  `IHDK_ASSERT_ALWAYS(a_count_bound, cnt <= CW'(MAX_VERTICES), "entry count above capacity")
  `IHDK_ASSERT_NEXT(a_count_step, !busy && !done, $stable(cnt) || $past(start),
                    "entry count moved while idle")

endmodule

// ===== rtl/core/indexed_min_heap_decrease_key.sv =====
// Top level of the indexed binary min-heap with decrease-key.
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Word
// request   in         start high, busy low req (req_t)
// result    out        done, one cycle      result (rsp_t)
//
// The next word can be accepted at the edge that ends the done cycle. Each level that
// insert and decrease move up costs a parent read and a compare-and-write step; extract
// costs a left read, right read, compare and write per level. Look up reads the position
// map and then the slot, and a rejected word ends without a walk of the heap.
// After reset a clearing pass writes every position entry to absent, one per
// cycle; busy is high throughout.
// The result word shows with done, high for a single cycle; the receiver cannot stall.
module indexed_min_heap_decrease_key #(
  parameter int MAX_VERTICES = ihdk_pkg::MAX_VERTICES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ihdk_pkg::req_t req,
  output logic           done,
  output ihdk_pkg::rsp_t result
);
  import ihdk_pkg::*;

  // Slot index, count/position and position-map index widths.
  localparam int SW       = $clog2(MAX_VERTICES);
  localparam int CW       = $clog2(MAX_VERTICES + 1);
  localparam int PM_DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam int PIW      = $clog2(PM_DEPTH);

  logic           s_we;
  logic [SW-1:0]  s_waddr;
  entry_t         s_wdata;
  logic [SW-1:0]  s_raddr;
  entry_t         s_rdata;
  logic           p_we;
  logic [PIW-1:0] p_waddr;
  logic [CW-1:0]  p_wdata;
  logic [PIW-1:0] p_raddr;
  logic [CW-1:0]  p_rdata;

  // The sequencer walks the heap; entries moving through it stay in a holding
  // register so each level needs only one write to the slot RAM.
  ihdk_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .SW           (SW),
    .CW           (CW),
    .PIW          (PIW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .result  (result),
    .s_we    (s_we),
    .s_waddr (s_waddr),
    .s_wdata (s_wdata),
    .s_raddr (s_raddr),
    .s_rdata (s_rdata),
    .p_we    (p_we),
    .p_waddr (p_waddr),
    .p_wdata (p_wdata),
    .p_raddr (p_raddr),
    .p_rdata (p_rdata)
  );

  // Heap slots: distance and vertex side by side.
  ihdk_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_VERTICES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Position map: slot + 1 per vertex, zero when the vertex is absent.
  ihdk_ram #(
    .WIDTH (CW),
    .DEPTH (PM_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

endmodule
